[sv/json_string_unescape_utf8_macros.svh]
`ifndef JSON_STRING_UNESCAPE_UTF8_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_MACROS_SVH

// same-cycle implication
`define JSU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jsu check failed");

// next-cycle implication
`define JSU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jsu check failed");

`endif

[sv/jsu_pkg.sv]
package jsu_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_STR     = 3'd1,
    MODE_ESC     = 3'd2,
    MODE_HEX1    = 3'd3,
    MODE_WANT_BS = 3'd4,
    MODE_WANT_U  = 3'd5,
    MODE_HEX2    = 3'd6
  } mode_t;

  // one decoded job: kind, number of bytes minus one, bytes in send order
  typedef struct packed {
    logic [1:0]      kind;
    logic [1:0]      cnt;
    logic [3:0][7:0] bytes;
  } job_t;

endpackage

[sv/jsu_front.sv]
module jsu_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_action,
  input  logic [7:0]        in_byte_in,
  output logic              push_valid,
  input  logic              push_ready,
  output jsu_pkg::job_t     push_job
);

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_LF     = 8'h0a;

  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [7:0] t;
    begin
      t = 8'h00;
      case (c) inside
        [8'h30:8'h39]: t = c - 8'h30;
        [8'h61:8'h66]: t = c - 8'h57;
        [8'h41:8'h46]: t = c - 8'h37;
        default:       t = 8'h00;
      endcase
      hex_decode = {(c inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]}), t[3:0]};
    end
  endfunction

  function automatic logic [8:0] esc_map(input logic [7:0] c);
    begin
      case (c)
        CH_QUOTE:  esc_map = {1'b1, CH_QUOTE};
        CH_BSLASH: esc_map = {1'b1, CH_BSLASH};
        CH_SLASH:  esc_map = {1'b1, CH_SLASH};
        8'h62:     esc_map = {1'b1, 8'h08};
        8'h66:     esc_map = {1'b1, 8'h0c};
        8'h6e:     esc_map = {1'b1, 8'h0a};
        8'h72:     esc_map = {1'b1, 8'h0d};
        8'h74:     esc_map = {1'b1, 8'h09};
        default:   esc_map = 9'h000;
      endcase
    end
  endfunction

  function automatic jsu_pkg::job_t utf8_job(input logic [20:0] v);
    jsu_pkg::job_t j;
    begin
      j = '0;
      j.kind = jsu_pkg::KIND_DATA;
      if (v <= 21'h7f) begin
        j.cnt = 2'd0;
        j.bytes[0] = v[7:0];
      end else if (v <= 21'h7ff) begin
        j.cnt = 2'd1;
        j.bytes[0] = {3'b110, v[10:6]};
        j.bytes[1] = {2'b10, v[5:0]};
      end else if (v <= 21'hffff) begin
        j.cnt = 2'd2;
        j.bytes[0] = {4'b1110, v[15:12]};
        j.bytes[1] = {2'b10, v[11:6]};
        j.bytes[2] = {2'b10, v[5:0]};
      end else begin
        j.cnt = 2'd3;
        j.bytes[0] = {5'b11110, v[20:18]};
        j.bytes[1] = {2'b10, v[17:12]};
        j.bytes[2] = {2'b10, v[11:6]};
        j.bytes[3] = {2'b10, v[5:0]};
      end
      utf8_job = j;
    end
  endfunction

  function automatic jsu_pkg::job_t single_job(input logic [1:0] k, input logic [7:0] b);
    jsu_pkg::job_t j;
    begin
      j = '0;
      j.kind = k;
      j.bytes[0] = b;
      single_job = j;
    end
  endfunction

  jsu_pkg::mode_t mode_r, mode_nxt;
  logic [1:0]     digit_r, digit_nxt;
  logic [15:0]    accum_r, accum_nxt;
  logic [9:0]     high_r, high_nxt;

  logic        in_fire;
  logic [4:0]  hv;
  logic [8:0]  esc;
  logic [15:0] acc_new;
  logic        last_dig;
  logic        hi_rng;
  logic        lo_rng;
  logic        is_ws;
  logic [20:0] pair_cp;
  logic        has_res;
  jsu_pkg::job_t job;

  assign in_ready = push_ready;
  assign in_fire  = in_valid && in_ready;
  assign hv       = hex_decode(in_byte_in);
  assign esc      = esc_map(in_byte_in);
  assign acc_new  = {accum_r[11:0], hv[3:0]};
  assign last_dig = (digit_r == 2'd3);
  assign hi_rng   = (acc_new[15:10] == 6'b110110);
  assign lo_rng   = (acc_new[15:10] == 6'b110111);
  assign is_ws    = (in_byte_in == CH_SPACE) || (in_byte_in == CH_TAB) ||
                    (in_byte_in == CH_CR) || (in_byte_in == CH_LF);
  assign pair_cp  = 21'h10000 + {1'b0, high_r, acc_new[9:0]};

  // next state
  always_comb begin
    mode_nxt  = mode_r;
    digit_nxt = digit_r;
    accum_nxt = accum_r;
    high_nxt  = high_r;
    if (in_fire) begin
      if (in_action) begin
        mode_nxt  = jsu_pkg::MODE_IDLE;
        digit_nxt = 2'd0;
        accum_nxt = 16'h0000;
        high_nxt  = 10'h000;
      end else begin
        case (mode_r)
          jsu_pkg::MODE_STR: begin
            if (in_byte_in == CH_QUOTE || in_byte_in < CH_SPACE) begin
              mode_nxt  = jsu_pkg::MODE_IDLE;
              digit_nxt = 2'd0;
              accum_nxt = 16'h0000;
              high_nxt  = 10'h000;
            end else if (in_byte_in == CH_BSLASH) begin
              mode_nxt = jsu_pkg::MODE_ESC;
            end
          end
          jsu_pkg::MODE_ESC: begin
            if (in_byte_in == CH_U) begin
              mode_nxt  = jsu_pkg::MODE_HEX1;
              digit_nxt = 2'd0;
              accum_nxt = 16'h0000;
            end else if (esc[8]) begin
              mode_nxt = jsu_pkg::MODE_STR;
            end else begin
              mode_nxt  = jsu_pkg::MODE_IDLE;
              digit_nxt = 2'd0;
              accum_nxt = 16'h0000;
              high_nxt  = 10'h000;
            end
          end
          jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2: begin
            if (!hv[4]) begin
              mode_nxt  = jsu_pkg::MODE_IDLE;
              digit_nxt = 2'd0;
              accum_nxt = 16'h0000;
              high_nxt  = 10'h000;
            end else if (!last_dig) begin
              accum_nxt = acc_new;
              digit_nxt = digit_r + 2'd1;
            end else begin
              digit_nxt = 2'd0;
              accum_nxt = 16'h0000;
              if (mode_r == jsu_pkg::MODE_HEX1) begin
                if (hi_rng) begin
                  high_nxt = acc_new[9:0];
                  mode_nxt = jsu_pkg::MODE_WANT_BS;
                end else if (lo_rng) begin
                  mode_nxt = jsu_pkg::MODE_IDLE;
                  high_nxt = 10'h000;
                end else begin
                  mode_nxt = jsu_pkg::MODE_STR;
                end
              end else begin
                high_nxt = 10'h000;
                mode_nxt = lo_rng ? jsu_pkg::MODE_STR : jsu_pkg::MODE_IDLE;
              end
            end
          end
          jsu_pkg::MODE_WANT_BS: begin
            if (in_byte_in == CH_BSLASH) begin
              mode_nxt = jsu_pkg::MODE_WANT_U;
            end else begin
              mode_nxt  = jsu_pkg::MODE_IDLE;
              digit_nxt = 2'd0;
              accum_nxt = 16'h0000;
              high_nxt  = 10'h000;
            end
          end
          jsu_pkg::MODE_WANT_U: begin
            if (in_byte_in == CH_U) begin
              mode_nxt  = jsu_pkg::MODE_HEX2;
              digit_nxt = 2'd0;
              accum_nxt = 16'h0000;
            end else begin
              mode_nxt  = jsu_pkg::MODE_IDLE;
              digit_nxt = 2'd0;
              accum_nxt = 16'h0000;
              high_nxt  = 10'h000;
            end
          end
          default: begin
            if (is_ws) begin
              mode_nxt = jsu_pkg::MODE_IDLE;
            end else begin
              mode_nxt  = (in_byte_in == CH_QUOTE) ? jsu_pkg::MODE_STR : jsu_pkg::MODE_IDLE;
              digit_nxt = 2'd0;
              accum_nxt = 16'h0000;
              high_nxt  = 10'h000;
            end
          end
        endcase
      end
    end
  end

  // results
  always_comb begin
    has_res = 1'b0;
    job     = single_job(jsu_pkg::KIND_ERR, 8'h00);
    if (in_action) begin
      has_res = 1'b1;
    end else begin
      case (mode_r)
        jsu_pkg::MODE_STR: begin
          if (in_byte_in == CH_QUOTE) begin
            has_res = 1'b1;
            job     = single_job(jsu_pkg::KIND_DONE, 8'h00);
          end else if (in_byte_in < CH_SPACE) begin
            has_res = 1'b1;
          end else if (in_byte_in != CH_BSLASH) begin
            has_res = 1'b1;
            job     = single_job(jsu_pkg::KIND_DATA, in_byte_in);
          end
        end
        jsu_pkg::MODE_ESC: begin
          if (in_byte_in != CH_U) begin
            has_res = 1'b1;
            if (esc[8]) begin
              job = single_job(jsu_pkg::KIND_DATA, esc[7:0]);
            end
          end
        end
        jsu_pkg::MODE_HEX1: begin
          if (!hv[4]) begin
            has_res = 1'b1;
          end else if (last_dig && !hi_rng) begin
            has_res = 1'b1;
            if (!lo_rng) begin
              job = utf8_job({5'b00000, acc_new});
            end
          end
        end
        jsu_pkg::MODE_HEX2: begin
          if (!hv[4]) begin
            has_res = 1'b1;
          end else if (last_dig) begin
            has_res = 1'b1;
            if (lo_rng) begin
              job = utf8_job(pair_cp);
            end
          end
        end
        jsu_pkg::MODE_WANT_BS: begin
          has_res = (in_byte_in != CH_BSLASH);
        end
        jsu_pkg::MODE_WANT_U: begin
          has_res = (in_byte_in != CH_U);
        end
        default: begin
          has_res = !is_ws && (in_byte_in != CH_QUOTE);
        end
      endcase
    end
  end

  assign push_valid = in_fire && has_res;
  assign push_job   = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= jsu_pkg::MODE_IDLE;
      digit_r <= 2'd0;
      accum_r <= 16'h0000;
      high_r  <= 10'h000;
    end else begin
      mode_r  <= mode_nxt;
      digit_r <= digit_nxt;
      accum_r <= accum_nxt;
      high_r  <= high_nxt;
    end
  end

endmodule

[sv/jsu_queue.sv]
module jsu_queue #(
  parameter int DEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  jsu_pkg::job_t push_job,
  output logic          pop_valid,
  input  logic          pop_ready,
  output jsu_pkg::job_t pop_job
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  jsu_pkg::job_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

[sv/jsu_back.sv]
module jsu_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  jsu_pkg::job_t pop_job,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    out_kind,
  output logic [7:0]    out_data_byte,
  output logic          out_last
);

  jsu_pkg::job_t cur_r, cur_nxt;
  logic [1:0]    idx_r, idx_nxt;
  logic          busy_r, busy_nxt;
  logic          take;
  logic          fin;
  logic          load;

  assign out_valid     = busy_r;
  assign out_kind      = cur_r.kind;
  assign out_data_byte = cur_r.bytes[idx_r];
  assign out_last      = (idx_r == cur_r.cnt);

  assign take      = out_valid && out_ready;
  assign fin       = take && out_last;
  assign pop_ready = !busy_r || fin;
  assign load      = pop_valid && pop_ready;

  always_comb begin
    cur_nxt  = cur_r;
    idx_nxt  = idx_r;
    busy_nxt = busy_r;
    if (load) begin
      cur_nxt  = pop_job;
      idx_nxt  = 2'd0;
      busy_nxt = 1'b1;
    end else if (fin) begin
      busy_nxt = 1'b0;
    end else if (take) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

endmodule

[sv/json_string_unescape_utf8.sv]
// channel | ports                                               | moves
// input   | in_valid in_ready in_action in_byte_in              | one raw byte or end-of-input
// result  | out_valid out_ready out_kind out_data_byte out_last | one decoded byte, done or error
//
// one input item per cycle while the queue is not full; each result item is one transfer on the output port
// a \u escape gives 1 to 4 result items, which leave the output port one after another
// a job queue of QUEUE_DEPTH entries lets the decoder run ahead of the byte sender
// a taken item's first result is registered in the queue, then in the output register, before it is valid
// rst_n is synchronous, active low; it returns the decoder to idle and empties the queue
// in_ready drops only while the queue is full

`include "json_string_unescape_utf8_macros.svh"

module json_string_unescape_utf8 #(
  parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_action,
  input  logic [7:0] in_byte_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_data_byte,
  output logic       out_last
);

  logic          push_valid;
  logic          push_ready;
  jsu_pkg::job_t push_job;
  logic          pop_valid;
  logic          pop_ready;
  jsu_pkg::job_t pop_job;
  logic          out_take;
  logic          out_stat;
  logic          out_is_data;

  jsu_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_action  (in_action),
    .in_byte_in (in_byte_in),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  jsu_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_job       (pop_job),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_kind      (out_kind),
    .out_data_byte (out_data_byte),
    .out_last      (out_last)
  );

  assign out_take    = out_valid && out_ready;
  assign out_stat    = out_valid && (out_kind != jsu_pkg::KIND_DATA);
  assign out_is_data = out_valid && (out_kind == jsu_pkg::KIND_DATA);

  `JSU_ASSERT_NOW(a_status_single, out_stat, out_last && out_data_byte == 8'h00)
  `JSU_ASSERT_NEXT(a_seq_no_gap, out_take && !out_last, out_is_data)
  `JSU_ASSERT_NOW(a_kind_legal, out_valid, out_kind <= jsu_pkg::KIND_ERR)

endmodule

[tb/sv/tb_json_string_unescape_utf8.sv]
`timescale 1ns / 100ps

module tb_json_string_unescape_utf8;

  localparam int LIMIT_CYCLES = 200000;
  localparam int RANDOM_ITEMS = 180;
  localparam int DRAIN_CYCLES = 20;

  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_END  = 1'b1;

  // how an item's results are checked
  localparam logic [1:0] CHK_MODEL = 2'd0;
  localparam logic [1:0] CHK_NONE  = 2'd1;
  localparam logic [1:0] CHK_ONE   = 2'd2;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam logic [15:0] SURR_HI_FIRST = 16'hd800;
  localparam logic [15:0] SURR_HI_LAST  = 16'hdbff;
  localparam logic [15:0] SURR_LO_FIRST = 16'hdc00;
  localparam logic [15:0] SURR_LO_LAST  = 16'hdfff;

  typedef struct packed {
    logic       act;
    logic [7:0] c;
    logic [1:0] chk;
    logic [1:0] kind;
    logic [7:0] dbyte;
  } stim_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] dbyte;
    logic       last;
  } result_t;

  localparam logic [7:0] ESC_CHARS [8] = '{
    CH_QUOTE, CH_BSLASH, "/", "b", "f", "n", "r", "t"
  };

  localparam stim_t DIRECTED [30] = '{
    '{ACT_END,  8'h00,     CHK_ONE,   jsu_pkg::KIND_ERR,  8'h00},
    '{ACT_BYTE, " ",       CHK_NONE,  jsu_pkg::KIND_DATA, 8'h00},
    '{ACT_BYTE, 8'h00,     CHK_ONE,   jsu_pkg::KIND_ERR,  8'h00},
    '{ACT_BYTE, CH_QUOTE,  CHK_NONE,  jsu_pkg::KIND_DATA, 8'h00},
    '{ACT_BYTE, 8'hff,     CHK_ONE,   jsu_pkg::KIND_DATA, 8'hff},
    '{ACT_BYTE, 8'h1f,     CHK_ONE,   jsu_pkg::KIND_ERR,  8'h00},
    '{ACT_BYTE, CH_QUOTE,  CHK_NONE,  jsu_pkg::KIND_DATA, 8'h00},
    '{ACT_BYTE, CH_BSLASH, CHK_NONE,  jsu_pkg::KIND_DATA, 8'h00},
    '{ACT_BYTE, "q",       CHK_ONE,   jsu_pkg::KIND_ERR,  8'h00},
    '{ACT_BYTE, CH_QUOTE,  CHK_NONE,  jsu_pkg::KIND_DATA, 8'h00},
    '{ACT_BYTE, CH_BSLASH, CHK_NONE,  jsu_pkg::KIND_DATA, 8'h00},
    '{ACT_BYTE, CH_U,      CHK_NONE,  jsu_pkg::KIND_DATA, 8'h00},
    '{ACT_BYTE, "0",       CHK_NONE,  jsu_pkg::KIND_DATA, 8'h00},
    '{ACT_BYTE, "0",       CHK_NONE,  jsu_pkg::KIND_DATA, 8'h00},
    '{ACT_BYTE, "E",       CHK_NONE,  jsu_pkg::KIND_DATA, 8'h00},
    '{ACT_BYTE, "9",       CHK_MODEL, jsu_pkg::KIND_DATA, 8'h00},
    '{ACT_BYTE, CH_BSLASH, CHK_NONE,  jsu_pkg::KIND_DATA, 8'h00},
    '{ACT_BYTE, CH_U,      CHK_NONE,  jsu_pkg::KIND_DATA, 8'h00},
    '{ACT_BYTE, "D",       CHK_NONE,  jsu_pkg::KIND_DATA, 8'h00},
    '{ACT_BYTE, "c",       CHK_NONE,  jsu_pkg::KIND_DATA, 8'h00},
    '{ACT_BYTE, "0",       CHK_NONE,  jsu_pkg::KIND_DATA, 8'h00},
    '{ACT_BYTE, "0",       CHK_ONE,   jsu_pkg::KIND_ERR,  8'h00},
    '{ACT_BYTE, CH_QUOTE,  CHK_NONE,  jsu_pkg::KIND_DATA, 8'h00},
    '{ACT_BYTE, CH_BSLASH, CHK_NONE,  jsu_pkg::KIND_DATA, 8'h00},
    '{ACT_BYTE, CH_U,      CHK_NONE,  jsu_pkg::KIND_DATA, 8'h00},
    '{ACT_BYTE, "g",       CHK_ONE,   jsu_pkg::KIND_ERR,  8'h00},
    '{ACT_BYTE, CH_QUOTE,  CHK_NONE,  jsu_pkg::KIND_DATA, 8'h00},
    '{ACT_END,  8'h00,     CHK_ONE,   jsu_pkg::KIND_ERR,  8'h00},
    '{ACT_BYTE, CH_QUOTE,  CHK_NONE,  jsu_pkg::KIND_DATA, 8'h00},
    '{ACT_BYTE, CH_QUOTE,  CHK_ONE,   jsu_pkg::KIND_DONE, 8'h00}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_action = 1'b0;
  logic [7:0] in_byte_in = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_data_byte;
  logic       out_last;

  stim_t   stim_q [$];
  result_t decoded_q [$];
  result_t step_q [$];
  stim_t   cur_item;
  int      stim_idx = 0;
  int      n_acc = 0;
  int      cycles = 0;
  int      failures = 0;
  int      send_idle;
  int      recv_idle;

  // decoder state
  jsu_pkg::mode_t dec_mode = jsu_pkg::MODE_IDLE;
  logic [1:0]     hex_n = '0;
  logic [15:0]    hex_acc = '0;
  logic [9:0]     hi_half = '0;

  json_string_unescape_utf8 u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_byte_in    (in_byte_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_kind      (out_kind),
    .out_data_byte (out_data_byte),
    .out_last      (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  task automatic put_result(input logic [1:0] kind, input logic [7:0] b);
    step_q.insert(step_q.size(), '{kind, b, 1'b0});
  endtask

  task automatic fail_decode();
    dec_mode = jsu_pkg::MODE_IDLE;
    hex_n = '0;
    hex_acc = '0;
    hi_half = '0;
    step_q.delete();
    put_result(jsu_pkg::KIND_ERR, 8'h00);
  endtask

  task automatic put_utf8(input logic [20:0] cp);
    if (cp <= 21'h7f) begin
      put_result(jsu_pkg::KIND_DATA, cp[7:0]);
    end else if (cp <= 21'h7ff) begin
      put_result(jsu_pkg::KIND_DATA, {3'b110, cp[10:6]});
      put_result(jsu_pkg::KIND_DATA, {2'b10, cp[5:0]});
    end else if (cp <= 21'hffff) begin
      put_result(jsu_pkg::KIND_DATA, {4'b1110, cp[15:12]});
      put_result(jsu_pkg::KIND_DATA, {2'b10, cp[11:6]});
      put_result(jsu_pkg::KIND_DATA, {2'b10, cp[5:0]});
    end else begin
      put_result(jsu_pkg::KIND_DATA, {5'b11110, cp[20:18]});
      put_result(jsu_pkg::KIND_DATA, {2'b10, cp[17:12]});
      put_result(jsu_pkg::KIND_DATA, {2'b10, cp[11:6]});
      put_result(jsu_pkg::KIND_DATA, {2'b10, cp[5:0]});
    end
  endtask

  // advances the decoder by one item and leaves its results in step_q
  task automatic unescape_item(input logic act, input logic [7:0] c);
    int          d;
    logic [15:0] v;
    step_q.delete();
    if (act == ACT_END) begin
      fail_decode();
    end else begin
      case (dec_mode)
        jsu_pkg::MODE_STR: begin
          if (c == CH_QUOTE) begin
            dec_mode = jsu_pkg::MODE_IDLE;
            put_result(jsu_pkg::KIND_DONE, 8'h00);
          end else if (c < 8'h20) begin
            fail_decode();
          end else if (c == CH_BSLASH) begin
            dec_mode = jsu_pkg::MODE_ESC;
          end else begin
            put_result(jsu_pkg::KIND_DATA, c);
          end
        end
        jsu_pkg::MODE_ESC: begin
          dec_mode = jsu_pkg::MODE_STR;
          case (c)
            CH_QUOTE, CH_BSLASH, "/": put_result(jsu_pkg::KIND_DATA, c);
            "b": put_result(jsu_pkg::KIND_DATA, 8'h08);
            "f": put_result(jsu_pkg::KIND_DATA, 8'h0c);
            "n": put_result(jsu_pkg::KIND_DATA, 8'h0a);
            "r": put_result(jsu_pkg::KIND_DATA, 8'h0d);
            "t": put_result(jsu_pkg::KIND_DATA, 8'h09);
            CH_U: begin
              dec_mode = jsu_pkg::MODE_HEX1;
              hex_n = '0;
              hex_acc = '0;
            end
            default: fail_decode();
          endcase
        end
        jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2: begin
          d = hex_nibble(c);
          if (d < 0) begin
            fail_decode();
          end else begin
            hex_acc = {hex_acc[11:0], 4'(d)};
            if (hex_n < 2'd3) begin
              hex_n = hex_n + 2'd1;
            end else begin
              hex_n = '0;
              v = hex_acc;
              hex_acc = '0;
              if (dec_mode == jsu_pkg::MODE_HEX1) begin
                if (v >= SURR_HI_FIRST && v <= SURR_HI_LAST) begin
                  hi_half = v[9:0];
                  dec_mode = jsu_pkg::MODE_WANT_BS;
                end else if (v >= SURR_LO_FIRST && v <= SURR_LO_LAST) begin
                  fail_decode();
                end else begin
                  dec_mode = jsu_pkg::MODE_STR;
                  put_utf8({5'd0, v});
                end
              end else if (v < SURR_LO_FIRST || v > SURR_LO_LAST) begin
                fail_decode();
              end else begin
                put_utf8(21'h10000 + {1'b0, hi_half, v[9:0]});
                hi_half = '0;
                dec_mode = jsu_pkg::MODE_STR;
              end
            end
          end
        end
        jsu_pkg::MODE_WANT_BS: begin
          if (c != CH_BSLASH) fail_decode();
          else dec_mode = jsu_pkg::MODE_WANT_U;
        end
        jsu_pkg::MODE_WANT_U: begin
          if (c != CH_U) begin
            fail_decode();
          end else begin
            dec_mode = jsu_pkg::MODE_HEX2;
            hex_n = '0;
            hex_acc = '0;
          end
        end
        default: begin
          if (c == 8'h20 || c == 8'h09 || c == 8'h0d || c == 8'h0a) begin
            dec_mode = jsu_pkg::MODE_IDLE;
          end else if (c == CH_QUOTE) begin
            dec_mode = jsu_pkg::MODE_STR;
            hex_n = '0;
            hex_acc = '0;
            hi_half = '0;
          end else begin
            fail_decode();
          end
        end
      endcase
    end
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
  endtask

  task automatic push_byte(input logic [7:0] c);
    stim_q.insert(stim_q.size(), '{ACT_BYTE, c, CHK_MODEL, jsu_pkg::KIND_DATA, 8'h00});
  endtask

  task automatic push_hex4(input logic [15:0] v);
    logic [3:0] n;
    for (int k = 3; k >= 0; k--) begin
      n = v[k*4 +: 4];
      if (n < 4'd10) push_byte(8'("0") + 8'(n));
      else if ($urandom_range(0, 1) == 0) push_byte(8'("a") + 8'(n) - 8'd10);
      else push_byte(8'("A") + 8'(n) - 8'd10);
    end
  endtask

  task automatic push_escape_u(input logic [15:0] v);
    push_byte(CH_BSLASH);
    push_byte(CH_U);
    push_hex4(v);
  endtask

  task automatic push_segment();
    logic [7:0]  c;
    logic [15:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        do c = 8'($urandom_range(8'h20, 8'hff)); while (c == CH_QUOTE || c == CH_BSLASH);
        push_byte(c);
      end
      4: begin
        push_byte(CH_BSLASH);
        push_byte(ESC_CHARS[$urandom_range(0, 7)]);
      end
      5: push_escape_u(16'($urandom_range(16'h0000, 16'h007f)));
      6: push_escape_u(16'($urandom_range(16'h0080, 16'h07ff)));
      7: begin
        // skip over the surrogate range
        v = 16'($urandom_range(16'h0800, 16'hf7ff));
        if (v >= SURR_HI_FIRST) v = v + 16'h0800;
        push_escape_u(v);
      end
      default: begin
        push_escape_u(16'($urandom_range(SURR_HI_FIRST, SURR_HI_LAST)));
        push_escape_u(16'($urandom_range(SURR_LO_FIRST, SURR_LO_LAST)));
      end
    endcase
  endtask

  task automatic push_broken();
    logic [7:0]  c;
    logic [15:0] v;
    case ($urandom_range(0, 7))
      0: begin
        stim_q.insert(stim_q.size(),
                      '{ACT_END, 8'($urandom_range(0, 255)), CHK_MODEL,
                        jsu_pkg::KIND_DATA, 8'h00});
      end
      1: push_byte(8'($urandom_range(8'h00, 8'h1f)));
      2: begin
        push_byte(CH_BSLASH);
        do c = 8'($urandom_range(0, 255));
        while (c inside {CH_QUOTE, CH_BSLASH, "/", "b", "f", "n", "r", "t", CH_U});
        push_byte(c);
      end
      3: begin
        push_byte(CH_BSLASH);
        push_byte(CH_U);
        repeat ($urandom_range(0, 3)) push_byte("7");
        do c = 8'($urandom_range(0, 255)); while (hex_nibble(c) >= 0);
        push_byte(c);
      end
      4: push_escape_u(16'($urandom_range(SURR_LO_FIRST, SURR_LO_LAST)));
      5: begin
        push_escape_u(16'($urandom_range(SURR_HI_FIRST, SURR_HI_LAST)));
        if ($urandom_range(0, 1) == 0) begin
          do c = 8'($urandom_range(0, 255)); while (c == CH_BSLASH);
        end else begin
          push_byte(CH_BSLASH);
          do c = 8'($urandom_range(0, 255)); while (c == CH_U);
        end
        push_byte(c);
      end
      6: begin
        push_escape_u(16'($urandom_range(SURR_HI_FIRST, SURR_HI_LAST)));
        do v = 16'($urandom_range(0, 16'hffff)); while (v >= SURR_LO_FIRST && v <= SURR_LO_LAST);
        push_escape_u(v);
      end
      default: begin
        push_byte(CH_BSLASH);
        stim_q.insert(stim_q.size(),
                      '{ACT_END, 8'h00, CHK_MODEL, jsu_pkg::KIND_DATA, 8'h00});
      end
    endcase
  endtask

  // one string literal, sometimes noise or cut short by a broken sequence
  task automatic gen_string();
    logic [7:0] ws [4];
    int         n_seg;
    int         brk;
    ws = '{8'h20, 8'h09, 8'h0d, 8'h0a};
    repeat ($urandom_range(0, 2)) push_byte(ws[$urandom_range(0, 3)]);
    if ($urandom_range(0, 9) == 0) begin
      push_byte(8'($urandom_range(0, 255)));
    end else begin
      push_byte(CH_QUOTE);
      n_seg = $urandom_range(0, 6);
      brk = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n_seg) : -1;
      for (int i = 0; i < n_seg && i != brk; i++) push_segment();
      if (brk >= 0) push_broken();
      else push_byte(CH_QUOTE);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      cycles <= cycles + 1;
      if (n_acc < stim_q.size() / 3) begin
        send_idle = 7;
        recv_idle = 61;
      end else if (n_acc < 2 * stim_q.size() / 3) begin
        send_idle = 61;
        recv_idle = 7;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end

      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          $error("unexpected item: kind %0d data_byte %02h last %0b",
                 out_kind, out_data_byte, out_last);
          failures++;
        end else begin
          if (out_kind != decoded_q[0].kind) begin
            $error("kind: expected %0d, got %0d", decoded_q[0].kind, out_kind);
            failures++;
          end
          if (out_data_byte != decoded_q[0].dbyte) begin
            $error("data_byte: expected %02h, got %02h", decoded_q[0].dbyte, out_data_byte);
            failures++;
          end
          if (out_last != decoded_q[0].last) begin
            $error("last: expected %0b, got %0b", decoded_q[0].last, out_last);
            failures++;
          end
          void'(decoded_q.pop_front());
        end
      end

      if (in_valid && in_ready) begin
        unescape_item(cur_item.act, cur_item.c);
        case (cur_item.chk)
          CHK_MODEL: foreach (step_q[i]) decoded_q.insert(decoded_q.size(), step_q[i]);
          CHK_ONE:   decoded_q.insert(decoded_q.size(), '{cur_item.kind, cur_item.dbyte, 1'b1});
          default:   ;
        endcase
        n_acc++;
      end

      if (!in_valid || in_ready) begin
        if (stim_idx < stim_q.size() && $urandom_range(0, 99) >= send_idle) begin
          cur_item = stim_q[stim_idx];
          stim_idx++;
          in_valid <= 1'b1;
          in_action <= cur_item.act;
          in_byte_in <= cur_item.c;
        end else begin
          in_valid <= 1'b0;
        end
      end

      out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  initial begin
    for (int i = 0; i < $size(DIRECTED); i++) stim_q.insert(stim_q.size(), DIRECTED[i]);
    while (stim_q.size() < $size(DIRECTED) + RANDOM_ITEMS) gen_string();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    do @(negedge clk); while (n_acc < stim_q.size() || decoded_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (failures == 0 && decoded_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    while (cycles < LIMIT_CYCLES) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
